/* hdl/packbits_rle_encoder_core_defines.svh */
// Assertion macros shared by the encoder's RTL files.
`ifndef PACKBITS_RLE_ENCODER_CORE_DEFINES_SVH
`define PACKBITS_RLE_ENCODER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PRLE_CHECK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check an implication on every rising edge, reset included.
`define PRLE_CHECK_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* hdl/prle_pkg.sv */
// Types and constants shared by the PackBits encoder modules.
package prle_pkg;

  localparam int MAX_BLOCK  = 128;
  localparam int WORD_BYTES = 8;
  localparam int IDX_W      = $clog2(MAX_BLOCK);
  localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
  localparam int FILL_W     = $clog2(WORD_BYTES + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam logic [12:0] ROW_LEN_CAP = 13'h1FFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       row_end;
  } in_t;

  typedef struct packed {
    logic [63:0] code_word;
    logic [3:0]  byte_count;
    logic        burst_last;
    logic        row_done;
    logic [12:0] row_length;
  } out_t;

  // One code byte, or the end-of-beat marker.
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       last;
  } tok_t;

endpackage

/* hdl/prle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module prle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/prle_fifo.sv */
// Short token queue between the block former and the word packer.
module prle_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  prle_pkg::tok_t push_data,
  output logic          full,
  input  logic          pop,
  output prle_pkg::tok_t pop_data,
  output logic          empty
);

  prle_pkg::tok_t                   slots [prle_pkg::FIFO_DEPTH];
  logic [prle_pkg::FPTR_W-1:0]      wptr;
  logic [prle_pkg::FPTR_W-1:0]      rptr;
  logic [prle_pkg::FPTR_W:0]        fill;

  assign full     = (fill == (prle_pkg::FPTR_W + 1)'(prle_pkg::FIFO_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* hdl/prle_front.sv */
// Block former: classifies bytes into runs and literals and emits code bytes.
`include "packbits_rle_encoder_core_defines.svh"

module prle_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  prle_pkg::in_t  item,
  output logic           tok_valid,
  output prle_pkg::tok_t tok,
  input  logic           tok_ready
);

  typedef enum logic [3:0] {
    S_IDLE, S_FEED, S_FLUSH, S_RUN0, S_RUN1, S_LITH, S_LITB, S_SING0, S_SING1, S_END
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_RUN, MODE_LIT
  } mode_t;

  state_t                      state;
  mode_t                       block_mode;
  logic                        flushing;
  logic                        last;
  logic [7:0]                  pb0, pb1, pb2;
  logic [1:0]                  pn;
  logic [7:0]                  la0, la1;
  logic [1:0]                  lv;
  logic [7:0]                  run_byte;
  logic [prle_pkg::CNT_W-1:0]  run_len;
  logic [prle_pkg::CNT_W-1:0]  lit_cnt;
  logic [prle_pkg::IDX_W-1:0]  lit_idx;

  logic [prle_pkg::CNT_W-1:0]  run_inc, cnt_inc;
  logic                        triple, adv, lit_done, we, replay;
  logic [prle_pkg::IDX_W-1:0]  raddr;
  logic [7:0]                  rdata;
  state_t                      ret_state;

  assign item_stall = (state != S_IDLE);
  assign run_inc    = run_len + 1'b1;
  assign cnt_inc    = lit_cnt + 1'b1;
  assign triple     = (la0 == la1) && (la1 == pb0);
  assign adv        = tok_valid && tok_ready;
  assign lit_done   = ({1'b0, lit_idx} == (lit_cnt - 1'b1));
  assign ret_state  = flushing ? S_FLUSH : S_FEED;

  // A literal close in the feed step reloads the pending bytes instead of popping.
  assign replay = (block_mode == MODE_LIT) && (lv == 2'd2) &&
                  (triple || (cnt_inc >= prle_pkg::CNT_W'(prle_pkg::MAX_BLOCK)));

  // Emit one code byte per state that produces one.
  always_comb begin
    tok_valid   = 1'b1;
    tok.data    = 8'd0;
    tok.is_end  = 1'b0;
    tok.last    = 1'b0;
    unique case (state)
      S_RUN0:  tok.data = 8'(9'd257 - 9'(run_len));
      S_RUN1:  tok.data = run_byte;
      S_LITH:  tok.data = 8'(lit_cnt - 1'b1);
      S_LITB:  tok.data = rdata;
      S_SING0: tok.data = 8'd0;
      S_SING1: tok.data = la0;
      S_END: begin
        tok.is_end = 1'b1;
        tok.last   = last;
      end
      default: tok_valid = 1'b0;
    endcase
  end

  // Read address runs one step ahead so rdata always matches lit_idx.
  always_comb begin
    if (state == S_LITB) begin
      raddr = adv ? lit_idx + 1'b1 : lit_idx;
    end else begin
      raddr = '0;
    end
  end

  // Commit the oldest lookahead byte into the literal store.
  assign we = ((state == S_FEED) && (pn != 2'd0) &&
               (((block_mode == MODE_IDLE) && (lv != 2'd0) && (pb0 != la0)) ||
                ((block_mode == MODE_LIT) && (lv == 2'd2) && !triple))) ||
              ((state == S_FLUSH) && (block_mode == MODE_LIT) && (lv != 2'd0));

  prle_ram #(.WIDTH(8), .DEPTH(prle_pkg::MAX_BLOCK)) u_lit_store (
    .clk   (clk),
    .we    (we),
    .waddr (lit_cnt[prle_pkg::IDX_W-1:0]),
    .wdata (la0),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      block_mode <= MODE_IDLE;
      flushing   <= 1'b0;
      last       <= 1'b0;
      pn         <= 2'd0;
      lv         <= 2'd0;
      la0        <= 8'd0;
      la1        <= 8'd0;
      run_byte   <= 8'd0;
      run_len    <= '0;
      lit_cnt    <= '0;
      lit_idx    <= '0;
      pb0        <= 8'd0;
      pb1        <= 8'd0;
      pb2        <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            pb0      <= item.data_byte;
            pn       <= 2'd1;
            last     <= item.row_end;
            flushing <= 1'b0;
            state    <= S_FEED;
          end
        end
        S_FEED: begin
          if (pn == 2'd0) begin
            flushing <= last;
            state    <= last ? S_FLUSH : S_END;
          end else begin
            if (!replay) begin
              // Pop the head byte.
              pb0 <= pb1;
              pb1 <= pb2;
              pn  <= pn - 1'b1;
            end
            unique case (block_mode)
              MODE_RUN: begin
                if (pb0 == run_byte) begin
                  run_len <= run_inc;
                  if (run_inc >= prle_pkg::CNT_W'(prle_pkg::MAX_BLOCK)) begin
                    state <= S_RUN0;
                  end
                end else begin
                  la0   <= pb0;
                  lv    <= 2'd1;
                  state <= S_RUN0;
                end
              end
              MODE_LIT: begin
                if (lv != 2'd2) begin
                  if (lv == 2'd0) begin
                    la0 <= pb0;
                  end else begin
                    la1 <= pb0;
                  end
                  lv <= lv + 1'b1;
                end else if (triple) begin
                  // Close the literal block and replay the three equal bytes.
                  pb0   <= la0;
                  pb1   <= la1;
                  pb2   <= pb0;
                  pn    <= 2'd3;
                  lv    <= 2'd0;
                  state <= S_LITH;
                end else begin
                  lit_cnt <= cnt_inc;
                  la0     <= la1;
                  la1     <= pb0;
                  if (cnt_inc >= prle_pkg::CNT_W'(prle_pkg::MAX_BLOCK)) begin
                    pb0   <= la1;
                    pb1   <= pb0;
                    pn    <= 2'd2;
                    lv    <= 2'd0;
                    state <= S_LITH;
                  end
                end
              end
              default: begin
                if (lv == 2'd0) begin
                  la0 <= pb0;
                  lv  <= 2'd1;
                end else if (pb0 == la0) begin
                  lv         <= 2'd0;
                  block_mode <= MODE_RUN;
                  run_byte   <= la0;
                  run_len    <= prle_pkg::CNT_W'(2);
                  if (prle_pkg::MAX_BLOCK <= 2) begin
                    state <= S_RUN0;
                  end
                end else begin
                  block_mode <= MODE_LIT;
                  lit_cnt    <= prle_pkg::CNT_W'(1);
                  la0        <= pb0;
                  lv         <= 2'd1;
                end
              end
            endcase
          end
        end
        S_FLUSH: begin
          unique case (block_mode)
            MODE_RUN: state <= S_RUN0;
            MODE_LIT: begin
              if (lv != 2'd0) begin
                la0     <= la1;
                lv      <= lv - 1'b1;
                lit_cnt <= cnt_inc;
                if (cnt_inc >= prle_pkg::CNT_W'(prle_pkg::MAX_BLOCK)) begin
                  state <= S_LITH;
                end
              end else begin
                state <= S_LITH;
              end
            end
            default: state <= (lv != 2'd0) ? S_SING0 : S_END;
          endcase
        end
        S_RUN0: begin
          if (adv) begin
            state <= S_RUN1;
          end
        end
        S_RUN1: begin
          if (adv) begin
            block_mode <= MODE_IDLE;
            run_len    <= '0;
            state      <= ret_state;
          end
        end
        S_LITH: begin
          if (adv) begin
            lit_idx <= '0;
            state   <= S_LITB;
          end
        end
        S_LITB: begin
          if (adv) begin
            if (lit_done) begin
              lit_idx    <= '0;
              lit_cnt    <= '0;
              block_mode <= MODE_IDLE;
              state      <= ret_state;
            end else begin
              lit_idx <= lit_idx + 1'b1;
            end
          end
        end
        S_SING0: begin
          if (adv) begin
            state <= S_SING1;
          end
        end
        S_SING1: begin
          if (adv) begin
            lv    <= 2'd0;
            state <= S_FLUSH;
          end
        end
        S_END: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PRLE_CHECK(a_lit_nonempty, clk, rst, (state == S_LITB) |-> (lit_cnt != '0), "literal close with empty block")
  `PRLE_CHECK(a_busy_after_accept, clk, rst, (item_valid && !item_stall) |=> item_stall, "front idle right after accept")
  `PRLE_CHECK(a_idle_quiet, clk, rst, (state == S_IDLE) |-> !tok_valid, "token offered while idle")

endmodule

/* hdl/prle_back.sv */
// Word packer: gathers code bytes into words and marks beat and row ends.
`include "packbits_rle_encoder_core_defines.svh"

module prle_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_empty,
  input  prle_pkg::tok_t tok,
  output logic           tok_pop,
  output logic           code_valid,
  input  logic           code_stall,
  output prle_pkg::out_t code
);

  logic [63:0]                 word;
  logic [prle_pkg::FILL_W-1:0] fill;
  logic [12:0]                 row_total;
  logic                        full_word;
  logic                        word_out;

  assign tok_pop   = !tok_empty && (!code_valid || !code_stall);
  assign full_word = (fill == prle_pkg::FILL_W'(prle_pkg::WORD_BYTES));
  assign word_out  = tok_pop && (tok.is_end ? (fill != '0) : full_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      word       <= 64'd0;
      fill       <= '0;
      row_total  <= 13'd0;
    end else begin
      if (word_out) begin
        code_valid <= 1'b1;
      end else if (code_valid && !code_stall) begin
        code_valid <= 1'b0;
      end
      if (tok_pop) begin
        if (tok.is_end) begin
          // Flush the partial word as the beat's last word.
          if (fill != '0) begin
            code.code_word  <= word;
            code.byte_count <= 4'(fill);
            code.burst_last <= 1'b1;
            code.row_done   <= tok.last;
            code.row_length <= tok.last ? row_total : 13'd0;
          end
          word <= 64'd0;
          fill <= '0;
          if (tok.last) begin
            row_total <= 13'd0;
          end
        end else begin
          if (row_total != prle_pkg::ROW_LEN_CAP) begin
            row_total <= row_total + 1'b1;
          end
          if (full_word) begin
            code.code_word  <= word;
            code.byte_count <= 4'(fill);
            code.burst_last <= 1'b0;
            code.row_done   <= 1'b0;
            code.row_length <= 13'd0;
            word            <= {56'd0, tok.data};
            fill            <= prle_pkg::FILL_W'(1);
          end else begin
            word[fill*8 +: 8] <= tok.data;
            fill              <= fill + 1'b1;
          end
        end
      end
    end
  end

  `PRLE_CHECK(a_flush_sends, clk, rst, (tok_pop && tok.is_end && (fill != '0)) |=> (code_valid && code.burst_last), "partial word not flushed")
  `PRLE_CHECK(a_done_is_last, clk, rst, (code_valid && code.row_done) |-> code.burst_last, "row end not on last word")
  `PRLE_CHECK(a_fill_range, clk, rst, (fill <= prle_pkg::FILL_W'(prle_pkg::WORD_BYTES)), "pack fill overflow")

endmodule

/* hdl/packbits_rle_encoder_core.sv */
// Top level of the PackBits run-length encoder: former, queue and packer.
// A beat's code words pass from the former's states through the queue to the packer's registered output.
// A closing block emits its header and code bytes before the former takes the next byte.
// The former's sequencer sets the rate: one byte at a time, row ends add flush cycles.
// Reset (rst, synchronous, active high) clears all control state at once.
module packbits_rle_encoder_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  prle_pkg::in_t  item,
  output logic           code_valid,
  input  logic           code_stall,
  output prle_pkg::out_t code
);

  // Token channel between the former and the queue.
  logic           tok_valid;
  prle_pkg::tok_t tok;
  logic           q_full;

  // Queue to packer.
  logic           q_empty;
  logic           q_pop;
  prle_pkg::tok_t q_tok;

  // The former accepts a beat, walks it through run/literal decisions and
  // pushes code bytes, ending every beat with an end marker.
  prle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .tok_valid  (tok_valid),
    .tok        (tok),
    .tok_ready  (!q_full)
  );

  // Decouple the former from output back-pressure.
  prle_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tok_valid),
    .push_data (tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_tok),
    .empty     (q_empty)
  );

  // The packer holds a full word until the next token tells whether it
  // closes the beat, then drives the registered output.
  prle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_empty  (q_empty),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

endmodule

/* test/packbits_rle_encoder_core_tb.sv */
// Testbench for the PackBits run-length encoder core: random rows checked against a predictor.
`timescale 1ns / 100ps

module packbits_rle_encoder_core_tb;

  localparam int LIMIT_CYCLES = 20000;

  logic           clk;
  logic           rst;
  logic           item_valid;
  logic           item_stall;
  prle_pkg::in_t  item;
  logic           code_valid;
  logic           code_stall;
  prle_pkg::out_t code;

  packbits_rle_encoder_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .code_valid(code_valid), .code_stall(code_stall), .code(code)
  );

  // Predictor state: mirrors the encoder's block former and word packer.
  typedef enum logic [1:0] {BLK_IDLE, BLK_RUN, BLK_LIT} blk_mode_t;

  logic [7:0]  lit_mem [prle_pkg::MAX_BLOCK];
  int          lit_cnt;
  logic [7:0]  look [2];
  int          look_n;
  logic [7:0]  run_val;
  int          run_len;
  blk_mode_t   mode;
  int          row_total;
  logic [63:0] word_acc;
  int          word_fill;

  prle_pkg::in_t  byte_q [$];     // bytes still to offer
  prle_pkg::out_t code_exp_q [$]; // code words still to arrive

  int   sender_idle_pct;
  int   recv_idle_pct;
  bit   hold_recv;
  int   hold_cnt;
  int   mismatches;
  int   quiet_cycles;
  bit   stim_done;

  // Close the current word and queue it if it holds anything.
  task automatic ship_word();
    prle_pkg::out_t w;
    if (word_fill > 0) begin
      w = '0;
      w.code_word = word_acc;
      w.byte_count = 4'(word_fill);
      code_exp_q = {code_exp_q, w};
    end
    word_acc = '0;
    word_fill = 0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    word_acc |= 64'(b) << (8 * word_fill);
    word_fill++;
    if (row_total < int'(prle_pkg::ROW_LEN_CAP)) row_total++;
    if (word_fill >= prle_pkg::WORD_BYTES) ship_word();
  endtask

  task automatic end_run();
    put_byte(8'(257 - run_len));
    put_byte(run_val);
    run_len = 0;
    mode = BLK_IDLE;
  endtask

  task automatic end_literals();
    put_byte(8'(lit_cnt - 1));
    for (int i = 0; i < lit_cnt; i++) put_byte(lit_mem[i]);
    lit_cnt = 0;
    mode = BLK_IDLE;
  endtask

  task automatic add_literal(input logic [7:0] b);
    if (lit_cnt < prle_pkg::MAX_BLOCK) lit_mem[lit_cnt] = b;
    lit_cnt++;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0] a, c;
    if (mode == BLK_RUN) begin
      if (b == run_val) begin
        run_len++;
        if (run_len >= prle_pkg::MAX_BLOCK) end_run();
      end else begin
        end_run();
        look[0] = b;
        look_n = 1;
      end
    end else if (mode == BLK_LIT) begin
      if (look_n < 2) begin
        look[look_n] = b;
        look_n++;
      end else begin
        a = look[0];
        c = look[1];
        if (a == c && c == b) begin
          // three equal bytes ahead: close literals, restart as a run
          end_literals();
          look_n = 0;
          take_byte(a);
          take_byte(c);
          take_byte(b);
        end else begin
          add_literal(a);
          look[0] = c;
          look[1] = b;
          if (lit_cnt >= prle_pkg::MAX_BLOCK) begin
            end_literals();
            look_n = 0;
            take_byte(c);
            take_byte(b);
          end
        end
      end
    end else begin
      if (look_n == 0) begin
        look[0] = b;
        look_n = 1;
      end else begin
        a = look[0];
        look_n = 0;
        if (b == a) begin
          mode = BLK_RUN;
          run_val = a;
          run_len = 2;
          if (run_len >= prle_pkg::MAX_BLOCK) end_run();
        end else begin
          mode = BLK_LIT;
          lit_cnt = 0;
          add_literal(a);
          look[0] = b;
          look_n = 1;
        end
      end
    end
  endtask

  task automatic close_row();
    logic [7:0] x;
    if (mode == BLK_RUN) end_run();
    if (mode == BLK_LIT) begin
      while (look_n > 0) begin
        x = look[0];
        look[0] = look[1];
        look_n--;
        add_literal(x);
        if (lit_cnt >= prle_pkg::MAX_BLOCK) begin
          end_literals();
          break;
        end
      end
      if (mode == BLK_LIT) end_literals();
    end
    if (look_n > 0) begin
      put_byte(8'h00);
      put_byte(look[0]);
      look_n = 0;
    end
  endtask

  // Work out every code word one accepted beat causes.
  task automatic encode_beat(input prle_pkg::in_t it);
    int n0;
    prle_pkg::out_t w;
    n0 = code_exp_q.size();
    take_byte(it.data_byte);
    if (it.row_end) close_row();
    ship_word();
    if (code_exp_q.size() > n0) begin
      w = code_exp_q[$];
      w.burst_last = 1'b1;
      if (it.row_end) begin
        w.row_done = 1'b1;
        w.row_length = 13'(row_total);
      end
      code_exp_q[$] = w;
    end
    if (it.row_end) row_total = 0;
  endtask

  function automatic prle_pkg::in_t mk(input logic [7:0] b, input logic e);
    prle_pkg::in_t t;
    t.data_byte = b;
    t.row_end = e;
    return t;
  endfunction

  // Append one byte to the stimulus queue.
  task automatic queue_byte(input logic [7:0] b, input logic e);
    byte_q = {byte_q, mk(b, e)};
  endtask

  // Queue one row of length len; style picks runs, literals or a mix.
  task automatic queue_row(input int len, input int style);
    logic [7:0] b;
    b = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b = 8'($urandom);
        1: ;
        default: begin
          if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 3));
        end
      endcase
      queue_byte(b, i == len - 1);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fill the byte queue: directed rows first, then random rows.
  initial begin
    mode = BLK_IDLE;
    lit_cnt = 0;
    look_n = 0;
    run_val = '0;
    run_len = 0;
    row_total = 0;
    word_acc = '0;
    word_fill = 0;
    stim_done = 0;
    sender_idle_pct = 12;
    recv_idle_pct = 75;
    // single-byte row at each extreme
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // two equal, two different
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'hAA, 1'b1);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    // literals broken by a triple, then a single byte
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h07, 1'b0);
    queue_byte(8'h07, 1'b0);
    queue_byte(8'h07, 1'b0);
    queue_byte(8'h03, 1'b1);
    // literal block ending on a pair at the row end
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h20, 1'b1);
    // full-length run and full literal block crossing the block limit
    queue_row(130, 1);
    queue_row(131, 0);
    for (int k = 0; k < 24; k++) begin
      if (k == 8) begin
        sender_idle_pct = 75;
        recv_idle_pct = 12;
      end
      if (k == 16) begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_row($urandom_range(1, 12), $urandom_range(0, 2));
      while (byte_q.size() > 8) @(posedge clk);
    end
    while (byte_q.size() > 0) @(posedge clk);
    stim_done = 1;
  end

  // Driver: offer queued bytes, hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      item <= '0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) encode_beat(item);
      if (byte_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        item_valid <= 1'b1;
        item <= byte_q.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      code_stall <= 1'b1;
      hold_recv <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (!hold_recv && hold_cnt == 0 && byte_q.size() < 250) begin
        hold_recv <= 1'b1;
        hold_cnt <= 1;
        code_stall <= 1'b1;
      end else if (hold_recv) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt >= 300) hold_recv <= 1'b0;
        code_stall <= (hold_cnt < 300);
      end else begin
        code_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Monitor: compare each code beat with the oldest expected word.
  always @(posedge clk) begin
    prle_pkg::out_t want;
    if (!rst && code_valid && !code_stall) begin
      if (code_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected code beat %h", code);
      end else begin
        want = code_exp_q.pop_front();
        if (code.code_word !== want.code_word || code.byte_count !== want.byte_count ||
            code.burst_last !== want.burst_last || code.row_done !== want.row_done ||
            code.row_length !== want.row_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("code mismatch: want %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                     want.code_word, want.byte_count, want.burst_last, want.row_done,
                     want.row_length, code.code_word, code.byte_count, code.burst_last,
                     code.row_done, code.row_length);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (code_valid && !code_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT_CYCLES) begin
      $display("packbits_rle_encoder_core verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    @(posedge clk);
    while (item_valid || code_exp_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && code_exp_q.size() == 0)
      $display("packbits_rle_encoder_core verification clean");
    else
      $display("packbits_rle_encoder_core verification failed");
    $finish;
  end

endmodule
